/* rtl/core/cfct_pkg.sv */
`timescale 1ns / 1ps

package cfct_pkg;

  // Fixed field widths of a word.
  localparam int unsigned ID_W      = 16;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HITS_W    = 32;
  localparam int unsigned SLOT_W    = 4;

  // Longest data length code that carries payload; larger codes are clamped to it.
  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_t;

  // One classified word as it waits between the front and the back end.
  typedef struct packed {
    cmd_t                 cmd;
    logic [ID_W-1:0]      id;
    logic [LEN_W-1:0]     len;
    logic                 ext;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
    logic [SLOT_W-1:0]    slot;
    logic                 in_range;
  } item_t;

  // Contents of one table slot.
  typedef struct packed {
    logic [ID_W-1:0]      ident;
    logic [LEN_W-1:0]     len;
    logic                 ext;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
    logic [HITS_W-1:0]    hits;
  } entry_t;

endpackage

/* rtl/core/can_frame_capture_table.sv */
`timescale 1ns / 1ps
// Channel   | Handshake            | Word
// ----------+----------------------+----------------------------------------------
// input     | in_valid / in_stall  | command, frame_id, frame_len, frame_ext,
//           |                      | frame_payload, now_ms, read_slot
// output    | out_valid / out_stall| slot_index, slot_ident, slot_len, slot_ext,
//           |                      | slot_payload, slot_time, slot_hits
//
// A capture scans the table, reading one slot of the table memory per cycle, then
// fetches the chosen slot and registers its result; a read in range fetches its slot directly.
// Reset clears the sequencer, the queue and the slot valid bits; slots read as zero
// until first written, so no clearing pass is needed.
// A two-word input queue keeps accepting, until it is full, while the back end works or its result is
// stalled; the back end waits in its output state until the result is taken.
module can_frame_capture_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [cfct_pkg::ID_W-1:0]         frame_id,
  input  logic [cfct_pkg::LEN_W-1:0]        frame_len,
  input  logic                              frame_ext,
  input  logic [cfct_pkg::PAYLOAD_W-1:0]    frame_payload,
  input  logic [cfct_pkg::TIME_W-1:0]       now_ms,
  input  logic [cfct_pkg::SLOT_W-1:0]       read_slot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfct_pkg::SLOT_W-1:0]       slot_index,
  output logic [cfct_pkg::ID_W-1:0]         slot_ident,
  output logic [cfct_pkg::LEN_W-1:0]        slot_len,
  output logic                              slot_ext,
  output logic [cfct_pkg::PAYLOAD_W-1:0]    slot_payload,
  output logic [cfct_pkg::TIME_W-1:0]       slot_time,
  output logic [cfct_pkg::HITS_W-1:0]       slot_hits
);

  logic            q_valid;
  logic            q_pop;
  cfct_pkg::item_t q_item;

  // Front end: classification and queue.
  cfct_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .frame_id      (frame_id),
    .frame_len     (frame_len),
    .frame_ext     (frame_ext),
    .frame_payload (frame_payload),
    .now_ms        (now_ms),
    .read_slot     (read_slot),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back end: slot scan, table update and result register.
  cfct_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .slot_ident   (slot_ident),
    .slot_len     (slot_len),
    .slot_ext     (slot_ext),
    .slot_payload (slot_payload),
    .slot_time    (slot_time),
    .slot_hits    (slot_hits)
  );

endmodule

/* rtl/core/cfct_front.sv */
`timescale 1ns / 1ps

module cfct_front #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [cfct_pkg::ID_W-1:0]         frame_id,
  input  logic [cfct_pkg::LEN_W-1:0]        frame_len,
  input  logic                              frame_ext,
  input  logic [cfct_pkg::PAYLOAD_W-1:0]    frame_payload,
  input  logic [cfct_pkg::TIME_W-1:0]       now_ms,
  input  logic [cfct_pkg::SLOT_W-1:0]       read_slot,
  output logic                              q_valid,
  output cfct_pkg::item_t                   q_item,
  input  logic                              q_pop
);

  cfct_pkg::item_t          item_new;
  cfct_pkg::item_t          fifo [2];
  logic [1:0]               count;
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic                     accept;
  logic [cfct_pkg::LEN_W-1:0] len_c;

  // Clamp the length and zero the payload bytes beyond it.
  always_comb begin
    len_c = (frame_len > cfct_pkg::MAX_LEN) ? cfct_pkg::MAX_LEN : frame_len;
    item_new.cmd      = cfct_pkg::cmd_t'(command);
    item_new.id       = frame_id;
    item_new.len      = len_c;
    item_new.ext      = frame_ext;
    item_new.stamp    = now_ms;
    item_new.slot     = read_slot;
    item_new.in_range = (32'(read_slot) < 32'(SLOT_COUNT));
    for (int b = 0; b < 8; b++) begin
      item_new.payload[8*b +: 8] = (b < int'(len_c)) ? frame_payload[8*b +: 8] : 8'h00;
    end
  end

  // Two-entry queue towards the back end.
  assign accept   = in_valid && !in_stall;
  assign in_stall = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      fifo[wr_ptr] <= item_new;
    end
  end

endmodule

/* rtl/core/cfct_back.sv */
`timescale 1ns / 1ps

module cfct_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  cfct_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfct_pkg::SLOT_W-1:0]       slot_index,
  output logic [cfct_pkg::ID_W-1:0]         slot_ident,
  output logic [cfct_pkg::LEN_W-1:0]        slot_len,
  output logic                              slot_ext,
  output logic [cfct_pkg::PAYLOAD_W-1:0]    slot_payload,
  output logic [cfct_pkg::TIME_W-1:0]       slot_time,
  output logic [cfct_pkg::HITS_W-1:0]       slot_hits
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DATA,
    ST_OUT
  } state_t;

  state_t                      state;
  cfct_pkg::item_t             cur;
  logic [CNT_W-1:0]            cnt;
  logic                        chk_vld;
  logic [IDX_W-1:0]            chk_idx;
  logic                        have_match;
  logic [IDX_W-1:0]            match_idx;
  logic                        have_free;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            old_idx;
  logic [cfct_pkg::TIME_W-1:0] old_time;
  logic [IDX_W-1:0]            sel;

  cfct_pkg::entry_t            mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       slot_vld;
  cfct_pkg::entry_t            rd_data;
  logic                        rd_vld;
  logic [IDX_W-1:0]            ra;
  logic                        issue;
  logic                        mem_we;

  cfct_pkg::entry_t            ent;
  logic                        is_match;
  logic                        is_free;
  logic                        have_match_next;
  logic [IDX_W-1:0]            match_idx_next;
  logic                        have_free_next;
  logic [IDX_W-1:0]            free_idx_next;
  logic [IDX_W-1:0]            old_idx_next;
  logic [cfct_pkg::TIME_W-1:0] old_time_next;
  logic [IDX_W-1:0]            choice;
  logic                        scan_done;
  logic [cfct_pkg::HITS_W-1:0] base_hits;
  cfct_pkg::entry_t            wr_entry;
  cfct_pkg::entry_t            result;

  // Read address: the scan counter during a scan, the chosen slot otherwise.
  assign issue  = (state == ST_SCAN) && (cnt < CNT_END);
  assign ra     = (state == ST_SCAN) ? cnt[IDX_W-1:0] : sel;
  assign q_pop  = (state == ST_IDLE) && q_valid;
  assign mem_we = (state == ST_DATA) && (cur.cmd == cfct_pkg::CMD_CAPTURE);

  // Slot table with registered read; a slot never written reads as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sel] <= wr_entry;
    end
    rd_data <= mem[ra];
    rd_vld  <= slot_vld[ra];
  end

  assign ent = rd_vld ? rd_data : '0;

  // Scan step: first matching used slot, first free slot, oldest stamp.
  always_comb begin
    is_match        = (ent.hits != '0) && (ent.ident == cur.id);
    is_free         = (ent.hits == '0);
    have_match_next = have_match || is_match;
    match_idx_next  = have_match ? match_idx : chk_idx;
    have_free_next  = have_free || is_free;
    free_idx_next   = have_free ? free_idx : chk_idx;
    if ((chk_idx == '0) || (ent.stamp < old_time)) begin
      old_idx_next  = chk_idx;
      old_time_next = ent.stamp;
    end else begin
      old_idx_next  = old_idx;
      old_time_next = old_time;
    end
    if (have_match_next) begin
      choice = match_idx_next;
    end else if (have_free_next) begin
      choice = free_idx_next;
    end else begin
      choice = old_idx_next;
    end
    scan_done = chk_vld && (chk_idx == LAST_IDX);
  end

  // Update of the chosen slot: a new identifier restarts the count, which saturates.
  always_comb begin
    base_hits        = (ent.ident != cur.id) ? '0 : ent.hits;
    wr_entry.ident   = cur.id;
    wr_entry.len     = cur.len;
    wr_entry.ext     = cur.ext;
    wr_entry.payload = cur.payload;
    wr_entry.stamp   = cur.stamp;
    wr_entry.hits    = (&base_hits) ? base_hits : base_hits + 1'b1;
    result           = (cur.cmd == cfct_pkg::CMD_CAPTURE) ? wr_entry : ent;
  end

  // Scan bookkeeping and the current word.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld  <= 1'b0;
      slot_vld <= '0;
    end else begin
      chk_vld <= issue;
      if (mem_we) begin
        slot_vld[sel] <= 1'b1;
      end
    end
    chk_idx <= cnt[IDX_W-1:0];
    if (q_pop) begin
      cur        <= q_item;
      cnt        <= '0;
      have_match <= 1'b0;
      have_free  <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (chk_vld) begin
        have_match <= have_match_next;
        match_idx  <= match_idx_next;
        have_free  <= have_free_next;
        free_idx   <= free_idx_next;
        old_idx    <= old_idx_next;
        old_time   <= old_time_next;
      end
    end
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            sel <= IDX_W'(q_item.slot);
            if (q_item.cmd == cfct_pkg::CMD_CAPTURE) begin
              state <= ST_SCAN;
            end else if (q_item.in_range) begin
              state <= ST_FETCH;
            end else begin
              slot_index   <= q_item.slot;
              slot_ident   <= '0;
              slot_len     <= '0;
              slot_ext     <= 1'b0;
              slot_payload <= '0;
              slot_time    <= '0;
              slot_hits    <= '0;
              state        <= ST_OUT;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            sel   <= choice;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          slot_index   <= cfct_pkg::SLOT_W'(sel);
          slot_ident   <= result.ident;
          slot_len     <= result.len;
          slot_ext     <= result.ext;
          slot_payload <= result.payload;
          slot_time    <= result.stamp;
          slot_hits    <= result.hits;
          state        <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = (state == ST_OUT);

  // Scan data only arrives while scanning.
  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == ST_SCAN))
    else $error("scan data outside a scan");

  // A capture always leaves a nonzero count in its result.
  a_capture_hits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA && cur.cmd == cfct_pkg::CMD_CAPTURE) |=> (slot_hits != '0))
    else $error("capture result with zero count");

  // Taking a word from the queue always starts work on it.
  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE))
    else $error("word taken from queue without being processed");

endmodule
